@@ sv/motor_feedback_angle_unwrap_core_assert.svh @@
// Assertion macros used by the angle unwrap core top level.
// Expects clk and arst_n in the scope of each use.
`ifndef MOTOR_FEEDBACK_ANGLE_UNWRAP_CORE_ASSERT_SVH
`define MOTOR_FEEDBACK_ANGLE_UNWRAP_CORE_ASSERT_SVH

// same-cycle implication
`define MFAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfau assertion failed");

// next-cycle implication
`define MFAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfau assertion failed");

`endif

@@ sv/mfau_pkg.sv @@
// Package for the motor feedback angle unwrap core: widths, codes, record types.
// No dependencies.
package mfau_pkg;

	localparam int ROUND_BITS_DEF = 24;
	localparam int MOTORS         = 4;
	localparam int MIDX_W         = 2;
	localparam int ID_W           = 11;
	localparam int SCALE_W        = 20;
	localparam int CFG_INDEX_W    = 1;
	localparam int CFG_DATA_W     = 20;
	localparam int ANGLE_W        = 16;
	localparam int TURN_SHIFT     = 13;
	localparam int ROUND_OUT_W    = 24;
	localparam int TOTAL_W        = 38;
	localparam int DIST_W         = 46;
	localparam int S_TDATA_W      = 80;
	localparam int M_TDATA_W      = 216;

	localparam logic [ID_W-1:0]    BASE_ID_RST = 11'd513;
	localparam logic [SCALE_W-1:0] SCALE_RST   = 20'd10422;

	// half a mechanical turn in encoder counts, as a 17-bit signed step
	localparam logic signed [16:0] HALF_TURN     = 17'sd4096;
	localparam logic signed [16:0] NEG_HALF_TURN = -17'sd4096;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BASE_ID = 1'b0,
		REG_SCALE   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_MEASURE = 1'b0,
		OP_CAPTURE = 1'b1
	} op_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] prev_angle;
		logic [ANGLE_W-1:0] zero_angle;
	} angle_rec_t;

	typedef struct packed {
		logic              en;
		logic [MIDX_W-1:0] idx;
		angle_rec_t        rec;
	} angle_wr_t;

	// per-frame result fields that ride along the back pipeline
	typedef struct packed {
		logic                          matched;
		logic [MIDX_W-1:0]             motor_index;
		logic [ANGLE_W-1:0]            rotor_angle;
		logic [15:0]                   speed;
		logic [15:0]                   current_raw;
		logic [7:0]                    hall_byte;
		logic [ROUND_OUT_W-1:0]        round_count;
		logic [TOTAL_W-1:0]            abs_angle;
	} res_fields_t;

endpackage

@@ sv/mfau_track.sv @@
// Per-motor state store: angle memory (last/offset) with write bypass, turn counters.
// Depends on mfau_pkg.
module mfau_track #(
	parameter int ROUND_BITS = mfau_pkg::ROUND_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [mfau_pkg::MIDX_W-1:0]       rd_idx,
	output mfau_pkg::angle_rec_t              rd_data,
	input  mfau_pkg::angle_wr_t               wr,
	input  logic signed [ROUND_BITS-1:0]      turn_wr,
	output logic signed [ROUND_BITS-1:0]      turn [mfau_pkg::MOTORS]
);
	import mfau_pkg::*;

	angle_rec_t                   mem [MOTORS];
	logic [MOTORS-1:0]            vld_q;
	angle_rec_t                   rd_q;
	logic signed [ROUND_BITS-1:0] turn_q [MOTORS];

	// registered read; a write to the same entry on the same edge is passed through
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.rec;
		end
		if (rd_en) begin
			if (wr.en && (wr.idx == rd_idx)) begin
				rd_q <= wr.rec;
			end else if (vld_q[rd_idx]) begin
				rd_q <= mem[rd_idx];
			end else begin
				rd_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int k = 0; k < MOTORS; k++) begin
				turn_q[k] <= '0;
			end
		end else if (wr.en) begin
			vld_q[wr.idx]  <= 1'b1;
			turn_q[wr.idx] <= turn_wr;
		end
	end

	assign rd_data = rd_q;
	assign turn    = turn_q;

endmodule

@@ sv/motor_feedback_angle_unwrap_core.sv @@
// Channel  | Dir | Fields (lsb first)
// s_*      | in  | tdata: std_id[10:0], payload[74:11]; tuser: operation
// m_*      | out | tdata: motor_index..distance_diagonal; tuser: matched
// cfg_*    | in  | write-only register port, index 0 base id, 1 distance scale
// One item per cycle while m_tready is high; items pass stages 1-3 to m_tvalid.
// The angle memory is read on accept and written back when the item leaves
// stage 1; a same-entry write on that edge is bypassed into the read data.
// Reset loads config defaults and clears valid bits and turn counters; no sweep.
// Back-pressure ripples through the four stages; each holds its item when full.
// Top level of the motor feedback angle unwrap core.
// Depends on mfau_pkg, mfau_track and motor_feedback_angle_unwrap_core_assert.svh.
`include "motor_feedback_angle_unwrap_core_assert.svh"

module motor_feedback_angle_unwrap_core #(
	parameter int ROUND_BITS = mfau_pkg::ROUND_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mfau_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mfau_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mfau_pkg::S_TDATA_W-1:0]      s_tdata,  // std_id, payload, zero pad
	input  logic                                s_tuser,  // operation
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// motor_index, rotor_angle, speed, current_raw, hall_byte, round_count,
	// multi-turn angle, distance_forward, distance_diagonal, zero pad
	output logic [mfau_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tuser   // matched
);
	import mfau_pkg::*;

	localparam int RB  = ROUND_BITS;
	localparam int TW  = RB + TURN_SHIFT + 2;
	localparam int TXW = (TW > TOTAL_W) ? TW : TOTAL_W;
	localparam int RXW = (RB > ROUND_OUT_W) ? RB : ROUND_OUT_W;
	localparam int SW  = RB + 2;
	localparam int PW  = SW + SCALE_W + 1;
	localparam int DXW = (PW > DIST_W) ? PW : DIST_W;
	localparam logic signed [RB-1:0] TURN_MAX = {1'b0, {(RB-1){1'b1}}};
	localparam logic signed [RB-1:0] TURN_MIN = {1'b1, {(RB-1){1'b0}}};
	localparam logic signed [RB-1:0] TURN_ONE = RB'(1);

	// configuration
	logic [ID_W-1:0]    base_q;
	logic [SCALE_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_ID_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_ID: base_q  <= cfg_data[ID_W-1:0];
				REG_SCALE:   scale_q <= cfg_data[SCALE_W-1:0];
			endcase
		end
	end

	// pipeline control
	logic v1_q, v2_q, v3_q, vo_q;
	logic ld1, ld2, ld3, ld_o;
	logic accept;

	assign ld_o     = !vo_q || m_tready;
	assign ld3      = !v3_q || ld_o;
	assign ld2      = !v2_q || ld3;
	assign ld1      = !v1_q || ld2;
	assign s_tready = ld1;
	assign accept   = s_tvalid && ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (ld1)  v1_q <= s_tvalid;
			if (ld2)  v2_q <= v1_q;
			if (ld3)  v3_q <= v2_q;
			if (ld_o) vo_q <= v3_q;
		end
	end

	// stage 0: id match, issue memory read
	logic [ID_W:0]   id_diff;
	logic            in_match;

	assign id_diff  = {1'b0, s_tdata[ID_W-1:0]} - {1'b0, base_q};
	assign in_match = (id_diff[ID_W:MIDX_W] == '0);

	logic              op_s1;
	logic              match_s1;
	logic [MIDX_W-1:0] idx_s1;
	logic [55:0]       pl_s1;   // payload bytes 1..7

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= s_tuser;
			match_s1 <= in_match;
			idx_s1   <= id_diff[MIDX_W-1:0];
			pl_s1    <= s_tdata[ID_W+63:ID_W+8];
		end
	end

	// stage 1: read-modify-write of the motor's state
	angle_rec_t                trk_rd;
	angle_wr_t                 trk_wr;
	logic signed [RB-1:0]      turn_arr [MOTORS];
	logic signed [RB-1:0]      turn_old, turn_new;
	logic [ANGLE_W-1:0]        ang, zero_new;
	logic signed [16:0]        step;
	logic signed [TW-1:0]      total_w;
	logic signed [TXW-1:0]     total_x;
	logic signed [RXW-1:0]     round_x;
	res_fields_t               res_s1;

	mfau_track #(
		.ROUND_BITS(RB)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_match),
		.rd_idx  (id_diff[MIDX_W-1:0]),
		.rd_data (trk_rd),
		.wr      (trk_wr),
		.turn_wr (turn_new),
		.turn    (turn_arr)
	);

	assign ang      = pl_s1[55:40];
	assign turn_old = turn_arr[idx_s1];
	assign step     = $signed({1'b0, ang}) - $signed({1'b0, trk_rd.prev_angle});

	always_comb begin
		turn_new = turn_old;
		zero_new = trk_rd.zero_angle;
		if (op_t'(op_s1) == OP_CAPTURE) begin
			zero_new = ang;
		end else if ((step > HALF_TURN) && (turn_old != TURN_MIN)) begin
			turn_new = turn_old - TURN_ONE;
		end else if ((step < NEG_HALF_TURN) && (turn_old != TURN_MAX)) begin
			turn_new = turn_old + TURN_ONE;
		end
	end

	assign trk_wr.en             = v1_q && match_s1 && ld2;
	assign trk_wr.idx            = idx_s1;
	assign trk_wr.rec.prev_angle = ang;
	assign trk_wr.rec.zero_angle = zero_new;

	assign total_w = (TW'(turn_new) <<< TURN_SHIFT) + TW'($signed({1'b0, ang}))
		- TW'($signed({1'b0, zero_new}));
	assign total_x = TXW'(total_w);
	assign round_x = RXW'(turn_new);

	always_comb begin
		res_s1 = '0;
		if (match_s1) begin
			res_s1.matched     = 1'b1;
			res_s1.motor_index = idx_s1;
			res_s1.rotor_angle = ang;
			res_s1.speed       = pl_s1[39:24];
			res_s1.current_raw = pl_s1[23:8];
			res_s1.hall_byte   = pl_s1[7:0];
			res_s1.round_count = round_x[ROUND_OUT_W-1:0];
			res_s1.abs_angle   = total_x[TOTAL_W-1:0];
		end
	end

	// stage 2: odometry sums from the updated turn counters
	res_fields_t res_s2, res_s3;
	logic signed [SW-1:0] fwd_c, dia_c, fwd_s3, dia_s3;

	always_ff @(posedge clk) begin
		if (ld2 && v1_q) begin
			res_s2 <= res_s1;
		end
	end

	assign fwd_c = SW'(turn_arr[0]) - SW'(turn_arr[1]) - SW'(turn_arr[2]) + SW'(turn_arr[3]);
	assign dia_c = SW'(turn_arr[2]) + SW'(turn_arr[3]) - SW'(turn_arr[0]) - SW'(turn_arr[1]);

	always_ff @(posedge clk) begin
		if (ld3 && v2_q) begin
			res_s3 <= res_s2;
			fwd_s3 <= fwd_c;
			dia_s3 <= dia_c;
		end
	end

	// stage 3: scale multiply into the output register
	logic signed [PW-1:0]  fwd_p, dia_p;
	logic signed [DXW-1:0] fwd_x, dia_x;
	logic signed [PW-1:0]  scale_s;
	res_fields_t           res_o_q;
	logic [DIST_W-1:0]     fwd_o_q, dia_o_q;

	assign scale_s = PW'($signed({1'b0, scale_q}));
	assign fwd_p   = PW'(fwd_s3) * scale_s;
	assign dia_p   = PW'(dia_s3) * scale_s;
	assign fwd_x   = DXW'(fwd_p);
	assign dia_x   = DXW'(dia_p);

	always_ff @(posedge clk) begin
		if (ld_o && v3_q) begin
			res_o_q <= res_s3;
			fwd_o_q <= fwd_x[DIST_W-1:0];
			dia_o_q <= dia_x[DIST_W-1:0];
		end
	end

	assign m_tvalid = vo_q;
	assign m_tuser  = res_o_q.matched;
	assign m_tdata  = {4'b0, dia_o_q, fwd_o_q, res_o_q.abs_angle, res_o_q.round_count,
		res_o_q.hall_byte, res_o_q.current_raw, res_o_q.speed, res_o_q.rotor_angle,
		res_o_q.motor_index};

	// unmatched frames carry nothing but the distances
	`MFAU_ASSERT_NOW(a_unmatched_zero, m_tvalid && !m_tuser, m_tdata[119:0] == '0)
	`MFAU_ASSERT_NOW(a_capture_keeps_turn, trk_wr.en && (op_t'(op_s1) == OP_CAPTURE),
		turn_new == turn_old)
	`MFAU_ASSERT_NEXT(a_s1_holds, v1_q && !ld2, v1_q && $stable(idx_s1) && $stable(pl_s1))
	`MFAU_ASSERT_NOW(a_full_blocks, v1_q && v2_q && v3_q && vo_q && !m_tready, !s_tready)

endmodule
